// File: src/bfu_pkg.sv
// Shared constants and types of the bilinear frame upscaler.
package bfu_pkg;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 24;
    localparam int OUT_W      = 32;
    localparam int SIZE_W     = 13;
    localparam int WGT_W      = 8;
    localparam int POS_W      = COORD_W + 16;
    localparam int PROD_W     = 26;
    localparam int NUM_W      = 44;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;
    localparam int MAP_LAT    = DIV_STAGES + 2;

    localparam int SRC_W_DEF = 640;
    localparam int SRC_H_DEF = 480;

    localparam logic [SIZE_W-1:0] OUT_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] OUT_HEIGHT_RST = 13'd480;
    localparam logic [7:0]        ALPHA          = 8'hFF;

    localparam logic CFG_OUT_WIDTH  = 1'b0;
    localparam logic CFG_OUT_HEIGHT = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [PIX_W-1:0]   px;
    } t_item;

    typedef struct packed {
        logic             cmd;
        logic             x0p;
        logic             y0p;
        logic             x1p;
        logic             y1p;
        logic [WGT_W-1:0] wx;
        logic [WGT_W-1:0] wy;
    } t_side;

endpackage

// File: src/bilinear_frame_upscaler_unit.sv
// Top level of the bilinear frame upscaler.
// Input beats carry a command: a write stores src_pixel at source (coord_x, coord_y),
// writes outside the source frame are dropped; a read names an output pixel and
// yields one output beat with the bilinear pixel 0xFFRRGGBB. Writes yield no beat.
// Output beats come in the order of their reads. After acceptance a beat passes the
// position mapper (a radix-16 long divider per axis), the address register, the frame
// read and the horizontal and vertical blend registers. One beat is taken every cycle
// while the pipeline is not stalled. A read sees every write accepted before it.
// out_width and out_height must be written on the configuration port while no read
// is in flight; the block does not enforce this. The port is always ready. Zero is
// used as one. Reset clears the pipeline valid bits and loads 640 by 480; frame
// contents are undefined until written. When the receiver stalls a waiting beat, the
// whole pipeline holds and o_in_stall rises in the same cycle; nothing is lost.
module bilinear_frame_upscaler_unit import bfu_pkg::*; #(
    parameter int SRC_W = SRC_W_DEF,
    parameter int SRC_H = SRC_H_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [COORD_W-1:0] i_coord_x,
    input  logic [COORD_W-1:0] i_coord_y,
    input  logic [PIX_W-1:0]   i_src_pixel,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OUT_W-1:0]   o_out_pixel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_wdata
);

    logic              en;
    logic [SIZE_W-1:0] r_out_width;
    logic [SIZE_W-1:0] r_out_height;
    logic              r_mv [MAP_LAT];
    t_item             r_mi [MAP_LAT];
    logic              r_fv [2];
    t_side             r_fs [2];
    logic              r_bv [2];
    logic [POS_W-1:0]  fx;
    logic [POS_W-1:0]  fy;
    logic [PIX_W-1:0]  rd [4];
    logic [PIX_W-1:0]  pix;
    t_item             n_item;
    t_side             n_side;
    t_item             last;
    logic              x1p;
    logic              y1p;

    assign en          = !(r_bv[1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_bv[1];
    assign o_out_pixel = {ALPHA, pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OUT_WIDTH_RST;
            r_out_height <= OUT_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_wdata;
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_wdata;
                default:        r_out_width  <= r_out_width;
            endcase
        end
    end

    // The second neighbor sits in the other parity bank unless it is clamped to the first.
    assign x1p = fx[16] ^ (fx[POS_W-1:16] != COORD_W'(SRC_W - 1));
    assign y1p = fy[16] ^ (fy[POS_W-1:16] != COORD_W'(SRC_H - 1));

    assign n_item = '{cmd: i_cmd, cx: i_coord_x, cy: i_coord_y, px: i_src_pixel};
    assign last   = r_mi[MAP_LAT-1];
    assign n_side = '{cmd: last.cmd, x0p: fx[16], y0p: fy[16], x1p: x1p, y1p: y1p,
                      wx: fx[15:8], wy: fy[15:8]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAP_LAT; k++) begin
                r_mv[k] <= 1'b0;
            end
            r_fv[0] <= 1'b0;
            r_fv[1] <= 1'b0;
            r_bv[0] <= 1'b0;
            r_bv[1] <= 1'b0;
        end else if (en) begin
            r_mv[0] <= i_in_valid;
            for (int k = 1; k < MAP_LAT; k++) begin
                r_mv[k] <= r_mv[k-1];
            end
            r_fv[0] <= r_mv[MAP_LAT-1];
            r_fv[1] <= r_fv[0];
            r_bv[0] <= r_fv[1] && (r_fs[1].cmd == CMD_READ);
            r_bv[1] <= r_bv[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mi[0] <= n_item;
            for (int k = 1; k < MAP_LAT; k++) begin
                r_mi[k] <= r_mi[k-1];
            end
            r_fs[0] <= n_side;
            r_fs[1] <= r_fs[0];
        end
    end

    bfu_map #(.SRC(SRC_W)) u_map_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_coord_x),
        .i_size  (r_out_width),
        .o_pos   (fx)
    );

    bfu_map #(.SRC(SRC_H)) u_map_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_coord_y),
        .i_size  (r_out_height),
        .o_pos   (fy)
    );

    bfu_frame #(.SRC_W(SRC_W), .SRC_H(SRC_H)) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mv[MAP_LAT-1]),
        .i_cmd   (last.cmd),
        .i_cx    (last.cx),
        .i_cy    (last.cy),
        .i_px    (last.px),
        .i_x0    (fx[POS_W-1:16]),
        .i_y0    (fy[POS_W-1:16]),
        .o_rd    (rd)
    );

    bfu_blend u_blend (
        .i_clk (i_clk),
        .i_en  (en),
        .i_tl  (rd[{r_fs[1].y0p, r_fs[1].x0p}]),
        .i_tr  (rd[{r_fs[1].y0p, r_fs[1].x1p}]),
        .i_bl  (rd[{r_fs[1].y1p, r_fs[1].x0p}]),
        .i_br  (rd[{r_fs[1].y1p, r_fs[1].x1p}]),
        .i_wx  (r_fs[1].wx),
        .i_wy  (r_fs[1].wy),
        .o_pix (pix)
    );

endmodule

// File: src/bfu_map.sv
// Pipelined coordinate mapper: output coordinate to clamped Q16 source position.
module bfu_map import bfu_pkg::*; #(
    parameter int SRC = SRC_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [COORD_W-1:0] i_coord,
    input  logic [SIZE_W-1:0]  i_size,
    output logic [POS_W-1:0]   o_pos
);

    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [NUM_W-1:0]  n;
    } t_div;

    localparam logic [NUM_W-1:0] HI   = NUM_W'(SRC - 1) << 16;
    localparam logic [NUM_W-1:0] HALF = NUM_W'(32768);

    function automatic t_div div_step(t_div a, logic [SIZE_W-1:0] d);
        t_div            r;
        logic [SIZE_W:0] w;
        r = a;
        for (int i = 0; i < DIV_BITS; i++) begin
            w = {r.rem, r.n[NUM_W-1]};
            if (w >= {1'b0, d}) begin
                r.rem = SIZE_W'(w - {1'b0, d});
                r.n   = {r.n[NUM_W-2:0], 1'b1};
            end else begin
                r.rem = w[SIZE_W-1:0];
                r.n   = {r.n[NUM_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    t_div              r_div [DIV_STAGES+1];
    logic [SIZE_W-1:0] r_d   [DIV_STAGES+1];
    logic [PROD_W-1:0] n_prod;
    logic [NUM_W-1:0]  n_q;
    logic [NUM_W-1:0]  n_t;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  r_pos;

    assign n_prod = PROD_W'({i_coord, 1'b1}) * PROD_W'(SRC);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0].rem <= '0;
            r_div[0].n   <= NUM_W'({n_prod, 15'b0});
            r_d[0]       <= (i_size == '0) ? SIZE_W'(1) : i_size;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[k] <= div_step(r_div[k-1], r_d[k-1]);
                r_d[k]   <= r_d[k-1];
            end
        end
    end

    always_comb begin
        n_q = r_div[DIV_STAGES].n;
        n_t = n_q - HALF;
        if (n_q < HALF) begin
            n_pos = '0;
        end else if (n_t > HI) begin
            n_pos = POS_W'(HI);
        end else begin
            n_pos = n_t[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

// File: src/bfu_frame.sv
// Source frame store split into four parity banks, one write and four reads a cycle while i_en is high.
module bfu_frame import bfu_pkg::*; #(
    parameter int SRC_W = SRC_W_DEF,
    parameter int SRC_H = SRC_H_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic [COORD_W-1:0] i_cx,
    input  logic [COORD_W-1:0] i_cy,
    input  logic [PIX_W-1:0]   i_px,
    input  logic [COORD_W-1:0] i_x0,
    input  logic [COORD_W-1:0] i_y0,
    output logic [PIX_W-1:0]   o_rd [4]
);

    localparam int BW    = (SRC_W + 1) / 2;
    localparam int BH    = (SRC_H + 1) / 2;
    localparam int DEPTH = BW * BH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             n_wen;
    logic [1:0]       n_wbank;
    logic [AW-1:0]    n_waddr;
    logic [AW-1:0]    n_raddr [4];
    logic             r_wen;
    logic [1:0]       r_wbank;
    logic [AW-1:0]    r_waddr;
    logic [PIX_W-1:0] r_wdata;
    logic [AW-1:0]    r_raddr [4];
    logic [PIX_W-1:0] r_rd    [4];

    assign n_wen = i_valid && (i_cmd == CMD_WRITE)
                && ({1'b0, i_cx} < 13'(SRC_W)) && ({1'b0, i_cy} < 13'(SRC_H));
    assign n_wbank = {i_cy[0], i_cx[0]};
    assign n_waddr = AW'(32'(i_cy[COORD_W-1:1]) * 32'(BW) + 32'(i_cx[COORD_W-1:1]));

    for (genvar b = 0; b < 4; b++) begin : g_addr
        localparam logic [1:0] BANK = 2'(b);
        logic [COORD_W:0]   sx;
        logic [COORD_W:0]   sy;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        always_comb begin
            sx  = {1'b0, i_x0} + 13'(i_x0[0] ^ BANK[0]);
            sy  = {1'b0, i_y0} + 13'(i_y0[0] ^ BANK[1]);
            col = sx[COORD_W:1];
            row = sy[COORD_W:1];
            if (col > 12'(BW - 1)) begin
                col = 12'(BW - 1);
            end
            if (row > 12'(BH - 1)) begin
                row = 12'(BH - 1);
            end
            n_raddr[b] = AW'(32'(row) * 32'(BW) + 32'(col));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wen <= 1'b0;
        end else if (i_en) begin
            r_wen <= n_wen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wbank <= n_wbank;
            r_waddr <= n_waddr;
            r_wdata <= i_px;
            r_raddr <= n_raddr;
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [DEPTH];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_wen && (r_wbank == 2'(b))) begin
                    r_mem[r_waddr] <= r_wdata;
                end
                r_rd[b] <= r_mem[r_raddr[b]];
            end
        end
    end

    assign o_rd = r_rd;

endmodule

// File: src/bfu_blend.sv
// Two-stage bilinear blend: horizontal lerps, then the vertical lerp.
module bfu_blend import bfu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [PIX_W-1:0] i_tl,
    input  logic [PIX_W-1:0] i_tr,
    input  logic [PIX_W-1:0] i_bl,
    input  logic [PIX_W-1:0] i_br,
    input  logic [WGT_W-1:0] i_wx,
    input  logic [WGT_W-1:0] i_wy,
    output logic [PIX_W-1:0] o_pix
);

    function automatic logic [PIX_W-1:0] lerp(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             logic [WGT_W-1:0] t);
        logic [PIX_W-1:0] r;
        logic [8:0]       s;
        logic [16:0]      sum;
        s = 9'd256 - {1'b0, t};
        for (int c = 0; c < 3; c++) begin
            sum = 17'(a[8*c +: 8]) * 17'(s) + 17'(b[8*c +: 8]) * 17'(t);
            r[8*c +: 8] = sum[15:8];
        end
        return r;
    endfunction

    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_bot;
    logic [WGT_W-1:0] r_wy;
    logic [PIX_W-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top <= lerp(i_tl, i_tr, i_wx);
            r_bot <= lerp(i_bl, i_br, i_wx);
            r_wy  <= i_wy;
            r_pix <= lerp(r_top, r_bot, r_wy);
        end
    end

    assign o_pix = r_pix;

endmodule
